FILE: design/bdrm_pkg.sv
// ----------------------------------------------------------------------------
// Battery drain rate monitor package
// Shared widths, constants, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package bdrm_pkg;

   // Sizing of the per-channel sample windows.
   localparam int NUM_UNITS = 3;
   localparam int WINDOW    = 10;

   localparam int UNIT_W    = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int SLOT_W    = $clog2(WINDOW);
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W     = CNT_W + 1;
   localparam int MEM_DEPTH = NUM_UNITS * WINDOW;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // Field widths.
   localparam int CHAN_W    = 2;
   localparam int LEVEL_W   = 14;
   localparam int TIME_W    = 32;
   localparam int DRAIN_W   = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 24;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 14'd10000;
   localparam int                 MS_PER_S  = 1000;

   // Register reset values.
   localparam logic [DRAIN_W-1:0] THRESHOLD_RESET = 24'd150;
   localparam logic [LEVEL_W-1:0] CRITICAL_RESET  = 14'd2000;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DRAIN_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_LEVEL  = 1'd1;

   // Input action and result kind codes.
   localparam logic ACTION_SAMPLE  = 1'b0;
   localparam logic ACTION_TICK    = 1'b1;
   localparam logic KIND_WARNING   = 1'b0;
   localparam logic KIND_SUMMARY   = 1'b1;

   // Which quantity the shared divider is working on.
   localparam logic [1:0] DIV_SEL_DRAIN = 2'd0;
   localparam logic [1:0] DIV_SEL_TTE   = 2'd1;
   localparam logic [1:0] DIV_SEL_TTC   = 2'd2;

   typedef struct packed {
      logic       load;
      logic       unit_first;
      logic       unit_next;
      logic       mem_write;
      logic       mem_read;
      logic       read_newest;
      logic       cap_old;
      logic       cap_new;
      logic       div_start;
      logic       div_take;
      logic [1:0] div_sel;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic chan_bad;
      logic fill_zero;
      logic drain_trivial;
      logic div_done;
      logic drain_nonzero;
      logic warn;
      logic crit_above;
      logic last_unit;
      logic rsp_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

FILE: design/bdrm_div.sv
// ----------------------------------------------------------------------------
// Battery drain rate monitor divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdrm_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bdrm_pkg::DRAIN_W-1:0] dividend,
   input  wire logic [bdrm_pkg::TIME_W-1:0]  divisor,
   output logic                             busy,
   output logic                             done,
   output logic [bdrm_pkg::DRAIN_W-1:0]     quotient
);
   import bdrm_pkg::*;

   localparam int STEP_W = $clog2(DRAIN_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [DRAIN_W-1:0]  quo_ff, quo_in;
   logic [TIME_W-1:0]   rem_ff, rem_in;
   logic [TIME_W-1:0]   dvs_ff, dvs_in;
   logic [TIME_W:0]     trial;
   logic                fits;

   assign trial = {rem_ff, quo_ff[DRAIN_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEP_W'(DRAIN_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DRAIN_W-2:0], fits};
         rem_in = fits ? TIME_W'(trial - {1'b0, dvs_ff}) : trial[TIME_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: design/bdrm_datapath.sv
// ----------------------------------------------------------------------------
// Battery drain rate monitor datapath
// Sample windows, window pointers, configuration, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdrm_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_action,
   input  wire logic [bdrm_pkg::CHAN_W-1:0]     req_channel,
   input  wire logic [bdrm_pkg::LEVEL_W-1:0]    req_battery_level,
   input  wire logic [bdrm_pkg::TIME_W-1:0]     req_time_ms,
   input  wire logic                            csr_we,
   input  wire logic [bdrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bdrm_pkg::CSR_W-1:0]      csr_wdata,
   input  wire bdrm_pkg::ctrl_cmd_type          cmd,
   output bdrm_pkg::ctrl_status_type            status,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_kind,
   output logic [bdrm_pkg::CHAN_W-1:0]          rsp_unit,
   output logic [bdrm_pkg::LEVEL_W-1:0]         rsp_level_now,
   output logic [bdrm_pkg::DRAIN_W-1:0]         rsp_drain_rate,
   output logic [bdrm_pkg::LEVEL_W-1:0]         rsp_secs_to_critical,
   output logic                                 rsp_critical_valid,
   output logic [bdrm_pkg::LEVEL_W-1:0]         rsp_secs_to_empty,
   output logic                                 rsp_empty_valid,
   output logic                                 rsp_last_row
);
   import bdrm_pkg::*;

   // Configuration.
   logic [DRAIN_W-1:0] thr_ff;
   logic [LEVEL_W-1:0] crit_ff;

   // Item under work.
   logic               act_ff, act_in;
   logic               bad_ff, bad_in;
   logic [UNIT_W-1:0]  unit_ff, unit_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic [TIME_W-1:0]  time_ff, time_in;

   // Window pointers per channel.
   logic [SLOT_W-1:0]  ws_ff   [NUM_UNITS];
   logic [SLOT_W-1:0]  ws_in   [NUM_UNITS];
   logic [CNT_W-1:0]   fill_ff [NUM_UNITS];
   logic [CNT_W-1:0]   fill_in [NUM_UNITS];

   // Window storage: time and level of every sample.
   logic [TIME_W+LEVEL_W-1:0] win_mem [MEM_DEPTH];
   logic [TIME_W+LEVEL_W-1:0] rd_data_ff;

   // Oldest and newest samples, computed quantities.
   logic [LEVEL_W-1:0] l0_ff, l0_in, l1_ff, l1_in;
   logic [TIME_W-1:0]  t0_ff, t0_in, t1_ff, t1_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic [LEVEL_W-1:0] tte_ff, tte_in, ttc_ff, ttc_in;

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [CHAN_W-1:0]  rsp_unit_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [DRAIN_W-1:0] rsp_drain_ff;
   logic [LEVEL_W-1:0] rsp_ttc_ff, rsp_tte_ff;
   logic               rsp_cv_ff, rsp_ev_ff, rsp_last_ff;

   logic [SLOT_W-1:0]  cur_ws;
   logic [CNT_W-1:0]   cur_fill;
   logic [SUM_W-1:0]   old_sum, new_sum;
   logic [SLOT_W-1:0]  old_slot, new_slot, rd_slot;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [LEVEL_W-1:0] lvl_drop, lvl_margin;
   logic               trivial, drain_nz, crit_above, later_any, rsp_free;
   logic               div_start, div_busy, div_done;
   logic [DRAIN_W-1:0] div_dividend, div_quo;
   logic [TIME_W-1:0]  div_divisor;

   assign cur_ws   = ws_ff[unit_ff];
   assign cur_fill = fill_ff[unit_ff];

   // Oldest and newest slots, modulo the window length.
   assign old_sum  = SUM_W'(cur_ws) + SUM_W'(WINDOW) - SUM_W'(cur_fill);
   assign new_sum  = SUM_W'(cur_ws) + SUM_W'(WINDOW) - SUM_W'(1);
   assign old_slot = (old_sum >= SUM_W'(WINDOW)) ? SLOT_W'(old_sum - SUM_W'(WINDOW))
                                                 : SLOT_W'(old_sum);
   assign new_slot = (new_sum >= SUM_W'(WINDOW)) ? SLOT_W'(new_sum - SUM_W'(WINDOW))
                                                 : SLOT_W'(new_sum);
   assign rd_slot  = cmd.read_newest ? new_slot : old_slot;
   assign wr_addr  = ADDR_W'(unit_ff) * ADDR_W'(WINDOW) + ADDR_W'(cur_ws);
   assign rd_addr  = ADDR_W'(unit_ff) * ADDR_W'(WINDOW) + ADDR_W'(rd_slot);

   assign lvl_drop   = l0_ff - l1_ff;
   assign lvl_margin = l1_ff - crit_ff;
   assign trivial    = (cur_fill < CNT_W'(2)) || (t1_ff <= t0_ff) || (l1_ff >= l0_ff);
   assign drain_nz   = drain_ff != '0;
   assign crit_above = l1_ff > crit_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      later_any = 1'b0;
      for (int i = 0; i < NUM_UNITS; i++) begin
         if (i > int'(unit_ff) && fill_ff[i] != '0) later_any = 1'b1;
      end
   end

   // Shared divider operand selection.
   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_DRAIN: begin
            div_dividend = DRAIN_W'(lvl_drop) * DRAIN_W'(MS_PER_S);
            div_divisor  = t1_ff - t0_ff;
         end
         DIV_SEL_TTE: begin
            div_dividend = DRAIN_W'(l1_ff);
            div_divisor  = TIME_W'(drain_ff);
         end
         DIV_SEL_TTC: begin
            div_dividend = DRAIN_W'(lvl_margin);
            div_divisor  = TIME_W'(drain_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = TIME_W'(1);
         end
      endcase
   end

   assign div_start = cmd.div_start && !(cmd.div_sel == DIV_SEL_DRAIN && trivial);

   bdrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      act_in   = act_ff;
      bad_in   = bad_ff;
      unit_in  = unit_ff;
      lvl_in   = lvl_ff;
      time_in  = time_ff;
      l0_in    = l0_ff;
      t0_in    = t0_ff;
      l1_in    = l1_ff;
      t1_in    = t1_ff;
      drain_in = drain_ff;
      tte_in   = tte_ff;
      ttc_in   = ttc_ff;
      ws_in    = ws_ff;
      fill_in  = fill_ff;
      if (cmd.load) begin
         act_in  = req_action;
         bad_in  = int'(req_channel) >= NUM_UNITS;
         unit_in = (int'(req_channel) >= NUM_UNITS) ? '0 : UNIT_W'(req_channel);
         lvl_in  = (req_battery_level > LEVEL_MAX) ? LEVEL_MAX : req_battery_level;
         time_in = req_time_ms;
      end
      if (cmd.unit_first) unit_in = '0;
      if (cmd.unit_next)  unit_in = unit_ff + UNIT_W'(1);
      if (cmd.mem_write) begin
         ws_in[unit_ff] = (CNT_W'(cur_ws) + CNT_W'(1) == CNT_W'(WINDOW))
                          ? '0 : cur_ws + SLOT_W'(1);
         if (cur_fill < CNT_W'(WINDOW)) fill_in[unit_ff] = cur_fill + CNT_W'(1);
      end
      if (cmd.cap_old) begin
         l0_in = rd_data_ff[LEVEL_W-1:0];
         t0_in = rd_data_ff[TIME_W+LEVEL_W-1:LEVEL_W];
      end
      if (cmd.cap_new) begin
         l1_in = rd_data_ff[LEVEL_W-1:0];
         t1_in = rd_data_ff[TIME_W+LEVEL_W-1:LEVEL_W];
      end
      if (cmd.div_start && cmd.div_sel == DIV_SEL_DRAIN && trivial) drain_in = '0;
      if (cmd.div_take) begin
         case (cmd.div_sel)
            DIV_SEL_DRAIN: drain_in = div_quo;
            DIV_SEL_TTE:   tte_in   = div_quo[LEVEL_W-1:0];
            DIV_SEL_TTC:   ttc_in   = div_quo[LEVEL_W-1:0];
            default:       drain_in = drain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THRESHOLD_RESET;
         crit_ff <= CRITICAL_RESET;
         for (int i = 0; i < NUM_UNITS; i++) begin
            ws_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         if (csr_we && csr_index == CSR_DRAIN_THRESHOLD) thr_ff <= csr_wdata[DRAIN_W-1:0];
         if (csr_we && csr_index == CSR_CRITICAL_LEVEL) crit_ff <= csr_wdata[LEVEL_W-1:0];
         ws_ff   <= ws_in;
         fill_ff <= fill_in;
      end
      act_ff   <= act_in;
      bad_ff   <= bad_in;
      unit_ff  <= unit_in;
      lvl_ff   <= lvl_in;
      time_ff  <= time_in;
      l0_ff    <= l0_in;
      t0_ff    <= t0_in;
      l1_ff    <= l1_in;
      t1_ff    <= t1_in;
      drain_ff <= drain_in;
      tte_ff   <= tte_in;
      ttc_ff   <= ttc_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) win_mem[wr_addr] <= {time_ff, lvl_ff};
      if (cmd.mem_read)  rd_data_ff <= win_mem[rd_addr];
   end

   // Result register: a warning carries no time estimates; a summary row marks
   // the last channel that holds samples.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_unit_ff  <= CHAN_W'(unit_ff);
         rsp_level_ff <= l1_ff;
         rsp_drain_ff <= drain_ff;
         if (act_ff == ACTION_TICK) begin
            rsp_kind_ff <= KIND_SUMMARY;
            rsp_ev_ff   <= drain_nz;
            rsp_tte_ff  <= drain_nz ? tte_ff : '0;
            rsp_cv_ff   <= drain_nz && crit_above;
            rsp_ttc_ff  <= (drain_nz && crit_above) ? ttc_ff : '0;
            rsp_last_ff <= !later_any;
         end else begin
            rsp_kind_ff <= KIND_WARNING;
            rsp_ev_ff   <= 1'b0;
            rsp_tte_ff  <= '0;
            rsp_cv_ff   <= 1'b0;
            rsp_ttc_ff  <= '0;
            rsp_last_ff <= 1'b1;
         end
      end
   end

   assign status.is_tick       = act_ff == ACTION_TICK;
   assign status.chan_bad      = bad_ff;
   assign status.fill_zero     = cur_fill == '0;
   assign status.drain_trivial = trivial;
   assign status.div_done      = div_done;
   assign status.drain_nonzero = drain_nz;
   assign status.warn          = (cur_fill >= CNT_W'(2)) && (drain_ff > thr_ff);
   assign status.crit_above    = crit_above;
   assign status.last_unit     = int'(unit_ff) == NUM_UNITS - 1;
   assign status.rsp_free      = rsp_free;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_unit             = rsp_unit_ff;
   assign rsp_level_now        = rsp_level_ff;
   assign rsp_drain_rate       = rsp_drain_ff;
   assign rsp_secs_to_critical = rsp_ttc_ff;
   assign rsp_critical_valid   = rsp_cv_ff;
   assign rsp_secs_to_empty    = rsp_tte_ff;
   assign rsp_empty_valid      = rsp_ev_ff;
   assign rsp_last_row         = rsp_last_ff;

   // The divider is never restarted while it still works on an earlier quotient.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> rsp_free)
      else $error("result register overwritten");

   // A warning is only raised for a nonzero drain rate and always marks the last row.
   a_warn_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_WARNING) |-> (rsp_drain_ff != '0 && rsp_last_ff))
      else $error("warning without drain");

   // A time to critical level is only reported alongside a time to empty.
   a_cv_implies_ev: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cv_ff) |-> rsp_ev_ff)
      else $error("critical time without empty time");

   // The fill count of the channel at work never exceeds the window length.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |=> (fill_ff[$past(unit_ff)] <= CNT_W'(WINDOW)))
      else $error("fill count beyond window");

endmodule

`default_nettype wire

FILE: design/bdrm_ctrl.sv
// ----------------------------------------------------------------------------
// Battery drain rate monitor controller
// Sequences window writes, window reads, divisions and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module bdrm_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   output bdrm_pkg::ctrl_cmd_type          cmd,
   input  wire bdrm_pkg::ctrl_status_type  status
);
   import bdrm_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_CHECK      = 4'd1;
   localparam logic [3:0] S_WRITE      = 4'd2;
   localparam logic [3:0] S_SCAN       = 4'd3;
   localparam logic [3:0] S_RD_OLD     = 4'd4;
   localparam logic [3:0] S_RD_NEW     = 4'd5;
   localparam logic [3:0] S_CAP_NEW    = 4'd6;
   localparam logic [3:0] S_PREP       = 4'd7;
   localparam logic [3:0] S_DRAIN_WAIT = 4'd8;
   localparam logic [3:0] S_DECIDE     = 4'd9;
   localparam logic [3:0] S_TTE_WAIT   = 4'd10;
   localparam logic [3:0] S_TTC_START  = 4'd11;
   localparam logic [3:0] S_TTC_WAIT   = 4'd12;
   localparam logic [3:0] S_EMIT       = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.is_tick) begin
               cmd.unit_first = 1'b1;
               state_in       = S_SCAN;
            end else if (status.chan_bad) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = S_RD_OLD;
         end
         S_SCAN: begin
            if (!status.fill_zero) begin
               state_in = S_RD_OLD;
            end else if (status.last_unit) begin
               state_in = S_IDLE;
            end else begin
               cmd.unit_next = 1'b1;
            end
         end
         S_RD_OLD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_RD_NEW;
         end
         S_RD_NEW: begin
            cmd.cap_old     = 1'b1;
            cmd.mem_read    = 1'b1;
            cmd.read_newest = 1'b1;
            state_in        = S_CAP_NEW;
         end
         S_CAP_NEW: begin
            cmd.cap_new = 1'b1;
            state_in    = S_PREP;
         end
         S_PREP: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_DRAIN;
            state_in      = status.drain_trivial ? S_DECIDE : S_DRAIN_WAIT;
         end
         S_DRAIN_WAIT: begin
            cmd.div_sel = DIV_SEL_DRAIN;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!status.is_tick) begin
               state_in = status.warn ? S_EMIT : S_IDLE;
            end else if (status.drain_nonzero) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_TTE;
               state_in      = S_TTE_WAIT;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_TTE_WAIT: begin
            cmd.div_sel = DIV_SEL_TTE;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = status.crit_above ? S_TTC_START : S_EMIT;
            end
         end
         S_TTC_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_TTC;
            state_in      = S_TTC_WAIT;
         end
         S_TTC_WAIT: begin
            cmd.div_sel = DIV_SEL_TTC;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               if (!status.is_tick || status.last_unit) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.unit_next = 1'b1;
                  state_in      = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

`default_nettype wire

FILE: design/battery_drain_rate_monitor_core.sv
// A warning leaves after its sample is written into the window, the oldest and newest
// entries are read back and one division forms the drain rate; a sample whose drain is
// trivially zero skips the division. A tick takes up to three divisions per channel with
// samples and a scan step per empty channel after the check, and waits out output stalls.
// Items are taken one at a time; the shared serial divider sets the pace.
// Reset (synchronous, active high) empties the windows, restores the registers, drops results.
// ----------------------------------------------------------------------------
// Battery drain rate monitor core
// Per-channel battery level windows with drain rate warnings and summaries.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_drain_rate_monitor_core (
   input  wire logic                            clock,
   input  wire logic                            reset,

   // Input items: battery samples and diagnostic ticks.
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_action,
   input  wire logic [bdrm_pkg::CHAN_W-1:0]     req_channel,
   input  wire logic [bdrm_pkg::LEVEL_W-1:0]    req_battery_level,
   input  wire logic [bdrm_pkg::TIME_W-1:0]     req_time_ms,

   // Result items: warnings and summary rows.
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_kind,
   output logic [bdrm_pkg::CHAN_W-1:0]          rsp_unit,
   output logic [bdrm_pkg::LEVEL_W-1:0]         rsp_level_now,
   output logic [bdrm_pkg::DRAIN_W-1:0]         rsp_drain_rate,
   output logic [bdrm_pkg::LEVEL_W-1:0]         rsp_secs_to_critical,
   output logic                                 rsp_critical_valid,
   output logic [bdrm_pkg::LEVEL_W-1:0]         rsp_secs_to_empty,
   output logic                                 rsp_empty_valid,
   output logic                                 rsp_last_row,

   // Register writes.
   input  wire logic                            csr_we,
   input  wire logic [bdrm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bdrm_pkg::CSR_W-1:0]      csr_wdata
);
   import bdrm_pkg::*;

   // The controller walks each item through its steps. A sample is written
   // into its channel's window, then the oldest and newest entries are read
   // back and the drain rate (level drop times 1000 over the time span) goes
   // through the serial divider. A tick visits the channels in order and, for
   // each one that holds samples, forms the drain rate and, if it is nonzero, the
   // time to empty and, above critical, to critical on that divider; then it emits the row.
   // The result register lets the next item be accepted while the last
   // result of the previous one still waits to be taken.

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   bdrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bdrm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_action           (req_action),
      .req_channel          (req_channel),
      .req_battery_level    (req_battery_level),
      .req_time_ms          (req_time_ms),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .cmd                  (cmd),
      .status               (status),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_unit             (rsp_unit),
      .rsp_level_now        (rsp_level_now),
      .rsp_drain_rate       (rsp_drain_rate),
      .rsp_secs_to_critical (rsp_secs_to_critical),
      .rsp_critical_valid   (rsp_critical_valid),
      .rsp_secs_to_empty    (rsp_secs_to_empty),
      .rsp_empty_valid      (rsp_empty_valid),
      .rsp_last_row         (rsp_last_row)
   );

endmodule

`default_nettype wire

FILE: test/tb_battery_drain_rate_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery drain rate monitor core testbench
// Feeds battery samples and diagnostic ticks through the item handshake and
// predicts every warning and summary row from a behavioral copy of the
// per-channel sample windows. Results are checked field by field in order.
// The run moves through several threshold and critical level settings.
// Both sides of the handshake idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------

module tb_battery_drain_rate_monitor_core;
   import bdrm_pkg::*;

   // Longest quiet stretch of a correct run is the long receiver hold
   // (LONG_HOLD) plus a full three-channel tick, a sender gap and the settle
   // time between phases. The limit is several times that.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int LONG_HOLD      = 600;

   // One input item as the sender presents it.
   typedef struct packed {
      logic               action;
      logic [CHAN_W-1:0]  chan;
      logic [LEVEL_W-1:0] level;
      logic [TIME_W-1:0]  stamp_ms;
   } battery_item_type;

   // One result item as the block reports it.
   typedef struct packed {
      logic               kind;
      logic [CHAN_W-1:0]  unit;
      logic [LEVEL_W-1:0] level_now;
      logic [DRAIN_W-1:0] drain;
      logic [LEVEL_W-1:0] secs_to_critical;
      logic               critical_valid;
      logic [LEVEL_W-1:0] secs_to_empty;
      logic               empty_valid;
      logic               last_row;
   } drain_row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_ALTERNATE,
      STALL_BURSTY
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid         = 1'b0;
   logic               req_stall;
   logic               req_action        = ACTION_SAMPLE;
   logic [CHAN_W-1:0]  req_channel       = '0;
   logic [LEVEL_W-1:0] req_battery_level = '0;
   logic [TIME_W-1:0]  req_time_ms       = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_kind;
   logic [CHAN_W-1:0]  rsp_unit;
   logic [LEVEL_W-1:0] rsp_level_now;
   logic [DRAIN_W-1:0] rsp_drain_rate;
   logic [LEVEL_W-1:0] rsp_secs_to_critical;
   logic               rsp_critical_valid;
   logic [LEVEL_W-1:0] rsp_secs_to_empty;
   logic               rsp_empty_valid;
   logic               rsp_last_row;

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DRAIN_THRESHOLD;
   logic [CSR_W-1:0]     csr_wdata = '0;

   battery_drain_rate_monitor_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_channel          (req_channel),
      .req_battery_level    (req_battery_level),
      .req_time_ms          (req_time_ms),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_unit             (rsp_unit),
      .rsp_level_now        (rsp_level_now),
      .rsp_drain_rate       (rsp_drain_rate),
      .rsp_secs_to_critical (rsp_secs_to_critical),
      .rsp_critical_valid   (rsp_critical_valid),
      .rsp_secs_to_empty    (rsp_secs_to_empty),
      .rsp_empty_valid      (rsp_empty_valid),
      .rsp_last_row         (rsp_last_row),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Behavioral copy of the block: per-channel windows and both registers.
   // ------------------------------------------------------------------------
   logic [LEVEL_W-1:0] lvl_hist   [NUM_UNITS][WINDOW];
   logic [TIME_W-1:0]  stamp_hist [NUM_UNITS][WINDOW];
   int                 next_slot  [NUM_UNITS] = '{default: 0};
   int                 hist_count [NUM_UNITS] = '{default: 0};
   logic [DRAIN_W-1:0] warn_threshold = THRESHOLD_RESET;
   logic [LEVEL_W-1:0] crit_mark      = CRITICAL_RESET;

   battery_item_type items_to_send [$];
   drain_row_type    awaited_rows  [$];

   // Counters for the closing summary and the verdict.
   int mismatches     = 0;
   int samples_taken  = 0;
   int ticks_taken    = 0;
   int warnings_seen  = 0;
   int summaries_seen = 0;

   // Drain over the whole window of one channel: the level lost between the
   // oldest and the newest entry, per second of their span. A window of one
   // entry, a span that does not move forward, or a level that did not fall
   // all give zero.
   function automatic logic [DRAIN_W-1:0] unit_drain(input int u);
      int              oldest;
      int              newest;
      longint unsigned l0;
      longint unsigned l1;
      longint unsigned t0;
      longint unsigned t1;
      if (hist_count[u] < 2) return '0;
      oldest = (next_slot[u] + WINDOW - hist_count[u]) % WINDOW;
      newest = (next_slot[u] + WINDOW - 1) % WINDOW;
      l0 = longint'(lvl_hist[u][oldest]);
      l1 = longint'(lvl_hist[u][newest]);
      t0 = longint'(stamp_hist[u][oldest]);
      t1 = longint'(stamp_hist[u][newest]);
      if (t1 <= t0 || l1 >= l0) return '0;
      return DRAIN_W'(((l0 - l1) * MS_PER_S) / (t1 - t0));
   endfunction

   // Applies one accepted item to the behavioral state and queues the rows
   // that it must cause.
   function automatic void predict_battery_rows(input battery_item_type it);
      int                 u;
      int                 slot;
      logic [LEVEL_W-1:0] lvl;
      logic [DRAIN_W-1:0] drain;
      drain_row_type      row;
      drain_row_type      tick_rows [$];
      if (it.action == ACTION_SAMPLE) begin
         u = int'(it.chan);
         if (u >= NUM_UNITS) return;
         lvl  = (it.level > LEVEL_MAX) ? LEVEL_MAX : it.level;
         slot = next_slot[u];
         lvl_hist[u][slot]   = lvl;
         stamp_hist[u][slot] = it.stamp_ms;
         next_slot[u] = (slot + 1) % WINDOW;
         if (hist_count[u] < WINDOW) hist_count[u]++;
         drain = unit_drain(u);
         if (hist_count[u] >= 2 && drain > warn_threshold) begin
            row           = '0;
            row.kind      = KIND_WARNING;
            row.unit      = CHAN_W'(u);
            row.level_now = lvl;
            row.drain     = drain;
            row.last_row  = 1'b1;
            awaited_rows  = {awaited_rows, row};
         end
         return;
      end
      // A tick reports every channel that holds samples, in channel order.
      for (u = 0; u < NUM_UNITS; u++) begin
         if (hist_count[u] == 0) continue;
         row           = '0;
         row.kind      = KIND_SUMMARY;
         row.unit      = CHAN_W'(u);
         row.level_now = lvl_hist[u][(next_slot[u] + WINDOW - 1) % WINDOW];
         row.drain     = unit_drain(u);
         if (row.drain != 0) begin
            row.empty_valid   = 1'b1;
            row.secs_to_empty = LEVEL_W'(row.level_now / row.drain);
            if (row.level_now > crit_mark) begin
               row.critical_valid   = 1'b1;
               row.secs_to_critical = LEVEL_W'((row.level_now - crit_mark) / row.drain);
            end
         end
         tick_rows = {tick_rows, row};
      end
      for (int k = 0; k < tick_rows.size(); k++) begin
         row = tick_rows[k];
         row.last_row = (k == tick_rows.size() - 1);
         awaited_rows = {awaited_rows, row};
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: presents queued items in bursts with random gaps between them.
   // A presented item stays on the port unchanged until it is accepted.
   // ------------------------------------------------------------------------
   battery_item_type offered;
   int               burst_left = 0;
   int               gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_battery_rows(offered);
            if (offered.action == ACTION_TICK) ticks_taken++;
            else samples_taken++;
         end
         if (req_valid && req_stall) begin
            // Item still waiting; keep it as it is.
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (items_to_send.size() > 0) begin
            offered = items_to_send[0];
            items_to_send.delete(0);
            req_valid         <= 1'b1;
            req_action        <= offered.action;
            req_channel       <= offered.chan;
            req_battery_level <= offered.level;
            req_time_ms       <= offered.stamp_ms;
            if (burst_left <= 1) begin
               // A zero gap joins two bursts into a longer busy stretch.
               burst_left = $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stalls on a pattern that is picked anew after a random stretch. Once
   // armed, it holds off for a long stretch so that the block backs up.
   // ------------------------------------------------------------------------
   logic           hold_armed = 1'b0;
   logic           hold_done  = 1'b0;
   int             hold_count = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             stall_tick = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_count++;
         if (hold_count >= LONG_HOLD) hold_done = 1'b1;
      end else begin
         stall_tick++;
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:      rsp_stall <= 1'b0;
            STALL_RANDOM:    rsp_stall <= ($urandom_range(0, 1) == 1);
            STALL_ALTERNATE: rsp_stall <= stall_tick[0];
            default:         rsp_stall <= ((stall_tick % 9) < 4);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: every accepted result is compared with the oldest expected row.
   // ------------------------------------------------------------------------
   function automatic bit field_ok(input string name, input longint unsigned want,
                                   input longint unsigned got);
      if (want == got) return 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
   endfunction

   drain_row_type seen_row;
   drain_row_type want_row;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_row = '{rsp_kind, rsp_unit, rsp_level_now, rsp_drain_rate,
                      rsp_secs_to_critical, rsp_critical_valid, rsp_secs_to_empty,
                      rsp_empty_valid, rsp_last_row};
         if (seen_row.kind == KIND_WARNING) warnings_seen++;
         else summaries_seen++;
         if (awaited_rows.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, seen_row);
            mismatches++;
         end else begin
            want_row = awaited_rows[0];
            awaited_rows.delete(0);
            mismatches += !field_ok("kind", want_row.kind, seen_row.kind);
            mismatches += !field_ok("unit", want_row.unit, seen_row.unit);
            mismatches += !field_ok("level_now", want_row.level_now, seen_row.level_now);
            mismatches += !field_ok("drain", want_row.drain, seen_row.drain);
            mismatches += !field_ok("secs_to_critical", want_row.secs_to_critical,
                                    seen_row.secs_to_critical);
            mismatches += !field_ok("critical_valid", want_row.critical_valid,
                                    seen_row.critical_valid);
            mismatches += !field_ok("secs_to_empty", want_row.secs_to_empty,
                                    seen_row.secs_to_empty);
            mismatches += !field_ok("empty_valid", want_row.empty_valid,
                                    seen_row.empty_valid);
            mismatches += !field_ok("last_row", want_row.last_row, seen_row.last_row);
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d rows still expected",
                     $time, quiet_cycles, awaited_rows.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   int          sim_level [NUM_UNITS] = '{default: 10000};
   logic [31:0] sim_time  [NUM_UNITS] = '{default: 0};

   task automatic push_item(input logic action, input logic [CHAN_W-1:0] chan,
                            input logic [LEVEL_W-1:0] level, input logic [TIME_W-1:0] stamp);
      battery_item_type it;
      it.action     = action;
      it.chan       = chan;
      it.level      = level;
      it.stamp_ms   = stamp;
      items_to_send = {items_to_send, it};
   endtask

   // Mostly draining sequences per channel with moving timestamps; the rest
   // is ticks and noise: the unused channel, levels past full scale, and
   // arbitrary timestamps that can jump backward.
   task automatic queue_random_items(input int count);
      int pick;
      int u;
      int step;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            push_item(ACTION_TICK, CHAN_W'($urandom_range(0, 3)),
                      LEVEL_W'($urandom_range(0, 16383)), TIME_W'($urandom));
         end else if (pick < 22) begin
            push_item(ACTION_SAMPLE, CHAN_W'($urandom_range(0, 3)),
                      LEVEL_W'($urandom_range(0, 16383)), TIME_W'($urandom));
         end else begin
            u    = $urandom_range(0, NUM_UNITS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               sim_level[u] = int'($urandom_range(8000, 10000));
            end else if (pick >= 12) begin
               step = $urandom_range(0, 400);
               sim_level[u] = (sim_level[u] > step) ? sim_level[u] - step : 0;
            end
            pick = $urandom_range(0, 99);
            if (pick >= 40) sim_time[u] += $urandom_range(50, 5000);
            else if (pick >= 6) sim_time[u] += $urandom_range(1, 50);
            push_item(ACTION_SAMPLE, CHAN_W'(u), LEVEL_W'(sim_level[u]), sim_time[u]);
         end
      end
   endtask

   // Waits until every item went in and every expected row came out, then
   // lets the block finish any item that produces no row. Checked between
   // edges so that the driver's updates at the edge have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (items_to_send.size() != 0 || req_valid || awaited_rows.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DRAIN_THRESHOLD) warn_threshold = val[DRAIN_W-1:0];
      else crit_mark = val[LEVEL_W-1:0];
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      // A tick before any sample produces nothing, the unused channel is
      // ignored, and a single sample reports no drain.
      push_item(ACTION_TICK,   2'd3, 14'd0,     32'd0);
      push_item(ACTION_SAMPLE, 2'd3, 14'h3FFF,  32'hFFFF_FFFF);
      push_item(ACTION_SAMPLE, 2'd0, 14'd10000, 32'd0);
      push_item(ACTION_TICK,   2'd0, 14'd0,     32'd0);
      // Full scale lost in one millisecond: the largest drain there is.
      push_item(ACTION_SAMPLE, 2'd0, 14'd0,     32'd1);
      // Saturated level, then a span of zero, then a span going backward.
      push_item(ACTION_SAMPLE, 2'd1, 14'h3FFF,  32'd1000);
      push_item(ACTION_SAMPLE, 2'd1, 14'd9000,  32'd1000);
      push_item(ACTION_SAMPLE, 2'd1, 14'd8000,  32'd500);
      push_item(ACTION_SAMPLE, 2'd1, 14'd10001, 32'd2000);
      // Timestamps at the top of their range.
      push_item(ACTION_SAMPLE, 2'd2, 14'd5000,  32'hFFFF_FFF0);
      push_item(ACTION_SAMPLE, 2'd2, 14'd4990,  32'hFFFF_FFFF);
      push_item(ACTION_TICK,   2'd1, 14'h2AAA,  32'h5555_5555);
      // A rising level clamps the drain at zero.
      push_item(ACTION_SAMPLE, 2'd2, 14'd6000,  32'hFFFF_FFFF);
      // Just above the critical level, then exactly on it.
      push_item(ACTION_SAMPLE, 2'd0, 14'd2001,  32'd5000);
      push_item(ACTION_TICK,   2'd2, 14'h1555,  32'hAAAA_AAAA);
      push_item(ACTION_SAMPLE, 2'd0, 14'd2000,  32'd6000);
      push_item(ACTION_TICK,   2'd0, 14'd0,     32'd0);
      wait_idle();

      // Lowest settings: every positive drain warns and every nonzero level is above critical.
      write_reg(CSR_DRAIN_THRESHOLD, 24'd0);
      write_reg(CSR_CRITICAL_LEVEL,  24'd0);
      queue_random_items(55);
      wait_idle();

      // Highest settings: no warning can fire and no level exceeds critical.
      write_reg(CSR_DRAIN_THRESHOLD, 24'd10000000);
      write_reg(CSR_CRITICAL_LEVEL,  24'd10000);
      queue_random_items(55);
      wait_idle();

      // Random settings, with the receiver holding off while items keep
      // coming so that the block fills up and stalls its input.
      write_reg(CSR_DRAIN_THRESHOLD, CSR_W'($urandom_range(100, 3000)));
      write_reg(CSR_CRITICAL_LEVEL,  CSR_W'($urandom_range(1, 9999)));
      queue_random_items(60);
      @(posedge clock);
      hold_armed <= 1'b1;
      wait_idle();

      // Back to the reset values.
      write_reg(CSR_DRAIN_THRESHOLD, THRESHOLD_RESET);
      write_reg(CSR_CRITICAL_LEVEL,  CSR_W'(CRITICAL_RESET));
      queue_random_items(60);
      wait_idle();

      $display("Covered %0d samples and %0d ticks under five register settings,",
               samples_taken, ticks_taken);
      $display("checking %0d warnings and %0d summary rows; %0d field mismatches.",
               warnings_seen, summaries_seen, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
